@@ rtl/sktab_pkg.sv @@
// sktab_pkg: shared types and codes for the sorted key table
// no dependencies; used by rtl/sorted_key_table.sv
`default_nettype none

package sktab_pkg;

  // item field widths
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RETRIEVE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REWIND   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NEXT     = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAIL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_ISSUE,
    S_INS_CHK,
    S_DEL_ISSUE,
    S_DEL_CHK,
    S_BS_ISSUE,
    S_BS_CHK,
    S_NXT_WAIT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/sorted_key_table.sv @@
// sorted_key_table: key/value table kept in ascending key order in one memory
// depends on rtl/sktab_pkg.sv
//
//   channel | signals                            | direction
//   --------+------------------------------------+----------
//   in      | in_valid, in_stall, mode/key/value | into block
//   out     | out_valid, out_stall, status,      | out of block
//           | out_key, out_value, count          |
//
// one item at a time; every access goes through the single entry memory
// (one read and one write a cycle, with registered read data).
// insert: downward scan from the top that shifts entries up as it goes
// delete: upward scan for the key, then later entries shift down; retrieve: binary search
// reset (rst, synchronous) empties the table and rewinds the cursor at once
// the result register lets the next item in while a result is stalled
`default_nettype none

module sorted_key_table #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [sktab_pkg::MODE_W-1:0]       mode,
  input  wire logic [sktab_pkg::DATA_W-1:0]       key,
  input  wire logic [sktab_pkg::DATA_W-1:0]       value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [sktab_pkg::STATUS_W-1:0]          status,
  output logic [sktab_pkg::DATA_W-1:0]            out_key,
  output logic [sktab_pkg::DATA_W-1:0]            out_value,
  output logic [$clog2(CAPACITY+1)-1:0]           count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int EW = KEY_BITS + sktab_pkg::DATA_W;
  localparam logic [CW-1:0] CAP   = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE   = CW'(1);
  localparam logic [CW-1:0] TWO   = CW'(2);
  localparam logic [CW-1:0] ZERO  = '0;

  // entry memory, key in the upper bits
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  // control state
  sktab_pkg::state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] cursor, cursor_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [CW-1:0] mid, mid_next;
  logic          found, found_next;

  // latched item and pending result
  logic [KEY_BITS-1:0]               key_r;
  logic [sktab_pkg::DATA_W-1:0]      value_r;
  logic [sktab_pkg::STATUS_W-1:0]    res_status, res_status_next;
  logic [KEY_BITS-1:0]               res_key, res_key_next;
  logic [sktab_pkg::DATA_W-1:0]      res_value, res_value_next;

  logic                 in_xfer;
  logic                 out_load;
  logic [KEY_BITS-1:0]  rkey;
  logic [sktab_pkg::DATA_W-1:0] rval;
  logic [CW:0]          mid_sum;
  logic                 last;

  assign in_stall = (state != sktab_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign rkey     = rdata[EW-1:sktab_pkg::DATA_W];
  assign rval     = rdata[sktab_pkg::DATA_W-1:0];
  assign mid_sum  = {1'b0, lo} + {1'b0, hi} - {{CW{1'b0}}, 1'b1};
  assign last     = (idx == cnt);

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // state register and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sktab_pkg::S_IDLE;
      cnt    <= '0;
      cursor <= '0;
      found  <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      cursor <= cursor_next;
      found  <= found_next;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
    res_value  <= res_value_next;
    if (in_xfer) begin
      key_r   <= key[KEY_BITS-1:0];
      value_r <= value;
    end
  end

  // next state, memory control and register updates
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    cursor_next     = cursor;
    idx_next        = idx;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    found_next      = found;
    res_status_next = res_status;
    res_key_next    = res_key;
    res_value_next  = res_value;
    raddr           = '0;
    we              = 1'b0;
    waddr           = '0;
    wdata           = {key_r, value_r};
    out_load        = 1'b0;

    case (state)
      sktab_pkg::S_IDLE: begin
        raddr = cursor[AW-1:0];
        if (in_xfer) begin
          res_status_next = sktab_pkg::ST_FAIL;
          res_key_next    = '0;
          res_value_next  = '0;
          state_next      = sktab_pkg::S_DONE;
          case (mode)
            sktab_pkg::MODE_INSERT: begin
              if (cnt != CAP) begin
                idx_next   = cnt;
                state_next = sktab_pkg::S_INS_ISSUE;
              end
            end
            sktab_pkg::MODE_DELETE: begin
              if (cnt != ZERO) begin
                found_next = 1'b0;
                state_next = sktab_pkg::S_DEL_ISSUE;
              end
            end
            sktab_pkg::MODE_RETRIEVE: begin
              if (cnt != ZERO) begin
                lo_next    = '0;
                hi_next    = cnt;
                state_next = sktab_pkg::S_BS_ISSUE;
              end
            end
            sktab_pkg::MODE_REWIND: begin
              cursor_next     = '0;
              res_status_next = sktab_pkg::ST_OK;
            end
            sktab_pkg::MODE_NEXT: begin
              // read of the cursor entry is already issued this cycle
              if (cursor < cnt) begin
                state_next = sktab_pkg::S_NXT_WAIT;
              end
            end
            default: begin
              res_status_next = sktab_pkg::ST_FAIL;
            end
          endcase
        end
      end

      // insert: walk down from the top, moving larger-or-equal entries up
      sktab_pkg::S_INS_ISSUE: begin
        if (idx == ZERO) begin
          we              = 1'b1;
          waddr           = '0;
          cnt_next        = cnt + ONE;
          res_status_next = sktab_pkg::ST_OK;
          state_next      = sktab_pkg::S_DONE;
        end else begin
          raddr      = AW'(idx - ONE);
          state_next = sktab_pkg::S_INS_CHK;
        end
      end

      sktab_pkg::S_INS_CHK: begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        if (!(rkey < key_r)) begin
          wdata    = rdata;
          idx_next = idx - ONE;
          if (idx == ONE) begin
            state_next = sktab_pkg::S_INS_ISSUE;
          end else begin
            raddr = AW'(idx - TWO);
          end
        end else begin
          cnt_next        = cnt + ONE;
          res_status_next = sktab_pkg::ST_OK;
          state_next      = sktab_pkg::S_DONE;
        end
      end

      // delete: scan up for the key, then move later entries down
      sktab_pkg::S_DEL_ISSUE: begin
        raddr      = '0;
        idx_next   = ONE;
        state_next = sktab_pkg::S_DEL_CHK;
      end

      sktab_pkg::S_DEL_CHK: begin
        if (found) begin
          we    = 1'b1;
          waddr = AW'(idx - TWO);
          wdata = rdata;
          if (last) begin
            cnt_next        = cnt - ONE;
            res_status_next = sktab_pkg::ST_OK;
            state_next      = sktab_pkg::S_DONE;
          end else begin
            raddr    = idx[AW-1:0];
            idx_next = idx + ONE;
          end
        end else if (rkey == key_r) begin
          if (last) begin
            cnt_next        = cnt - ONE;
            res_status_next = sktab_pkg::ST_OK;
            state_next      = sktab_pkg::S_DONE;
          end else begin
            found_next = 1'b1;
            raddr      = idx[AW-1:0];
            idx_next   = idx + ONE;
          end
        end else if (rkey < key_r && !last) begin
          raddr    = idx[AW-1:0];
          idx_next = idx + ONE;
        end else begin
          res_status_next = sktab_pkg::ST_NOT_FOUND;
          state_next      = sktab_pkg::S_DONE;
        end
      end

      // retrieve: binary search over [lo, hi), midpoint of lo and hi-1 rounded down
      sktab_pkg::S_BS_ISSUE: begin
        if (lo < hi) begin
          mid_next   = mid_sum[CW:1];
          raddr      = AW'(mid_sum[CW:1]);
          state_next = sktab_pkg::S_BS_CHK;
        end else begin
          res_status_next = sktab_pkg::ST_NOT_FOUND;
          state_next      = sktab_pkg::S_DONE;
        end
      end

      sktab_pkg::S_BS_CHK: begin
        if (key_r == rkey) begin
          res_status_next = sktab_pkg::ST_OK;
          res_key_next    = rkey;
          res_value_next  = rval;
          state_next      = sktab_pkg::S_DONE;
        end else if (key_r < rkey) begin
          hi_next    = mid;
          state_next = sktab_pkg::S_BS_ISSUE;
        end else begin
          lo_next    = mid + ONE;
          state_next = sktab_pkg::S_BS_ISSUE;
        end
      end

      // read next: entry data arrives in the cycle after the read
      sktab_pkg::S_NXT_WAIT: begin
        res_status_next = sktab_pkg::ST_OK;
        res_key_next    = rkey;
        res_value_next  = rval;
        cursor_next     = cursor + ONE;
        state_next      = sktab_pkg::S_DONE;
      end

      // hand the result to the output register once it is free
      sktab_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = sktab_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = sktab_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status    <= res_status;
      out_key   <= sktab_pkg::DATA_W'(res_key);
      out_value <= res_value;
      count     <= cnt;
    end
  end

endmodule

`default_nettype wire
